[hw/rtl/ubsd_pkg.sv]
// shared types and constants of the unicode byte stream decoder
`default_nettype none

package ubsd_pkg;

  // input_format codes
  localparam logic [2:0] FMT_UTF8    = 3'd0;
  localparam logic [2:0] FMT_UTF16LE = 3'd1;
  localparam logic [2:0] FMT_UTF16BE = 3'd2;
  localparam logic [2:0] FMT_UTF32LE = 3'd3;
  localparam logic [2:0] FMT_UTF32BE = 3'd4;

  localparam int unsigned CpWidth    = 31;
  localparam int unsigned LenWidth   = 3;
  localparam int unsigned OutDataW   = 40;  // code_point + seq_bytes, padded to bytes
  localparam int unsigned OutUsedW   = CpWidth + LenWidth;

  localparam logic [15:0] SurHighLo  = 16'hD800;
  localparam logic [15:0] SurLowLo   = 16'hDC00;
  localparam logic [15:0] SurEnd     = 16'hE000;
  localparam logic [31:0] MaxCpEnd   = 32'h0011_0000;
  localparam logic [31:0] SupplBase  = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  seen;
    logic [2:0]  expected;
    logic [7:0]  lead;
    logic [15:0] high_sur;
    logic        pair_pending;
  } dec_state_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_bytes;
    logic                decode_error;
  } dec_result_t;

endpackage

`default_nettype wire

[hw/rtl/ubsd_step.sv]
// per-byte decode logic: next sequence state and an optional result
`default_nettype none

module ubsd_step (
  input  var ubsd_pkg::dec_state_t  state_i,
  input  var logic [2:0]            format_i,
  input  var logic [7:0]            byte_i,
  output ubsd_pkg::dec_state_t      state_o,
  output logic                      res_valid_o,
  output ubsd_pkg::dec_result_t     res_o
);

  logic [2:0]  lead_len;
  logic        cont_ok;
  logic [31:0] acc8;
  logic [2:0]  seen_inc;
  logic [15:0] unit;
  logic [31:0] acc32;
  logic [1:0]  pos;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    lead_len    = 3'd0;
    cont_ok     = (byte_i[7:6] == 2'b10);
    acc8        = {state_i.acc[25:0], byte_i[5:0]};
    seen_inc    = state_i.seen + 3'd1;
    unit        = (format_i == ubsd_pkg::FMT_UTF16BE) ? {state_i.acc[7:0], byte_i}
                                                       : {byte_i, state_i.acc[7:0]};
    pos         = state_i.seen[1:0];
    acc32       = (format_i == ubsd_pkg::FMT_UTF32BE) ? {state_i.acc[23:0], byte_i}
                  : (state_i.acc | ({24'd0, byte_i} << {pos, 3'b000}));

    unique case (format_i)
      ubsd_pkg::FMT_UTF8: begin
        if (state_i.expected == 3'd0) begin
          priority if (byte_i < 8'h80) begin
            res_valid_o      = 1'b1;
            res_o.code_point = {23'd0, byte_i};
            res_o.seq_bytes  = 3'd1;
            state_o          = '0;
          end else if (byte_i < 8'hC2) begin
            res_valid_o        = 1'b1;
            res_o.seq_bytes    = 3'd1;
            res_o.decode_error = 1'b1;
            state_o            = '0;
          end else if (byte_i < 8'hFE) begin
            priority if (byte_i < 8'hE0) lead_len = 3'd2;
            else if (byte_i < 8'hF0)     lead_len = 3'd3;
            else if (byte_i < 8'hF8)     lead_len = 3'd4;
            else if (byte_i < 8'hFC)     lead_len = 3'd5;
            else                         lead_len = 3'd6;
            state_o.acc      = {24'd0, byte_i & (8'h7F >> lead_len)};
            state_o.expected = lead_len;
            state_o.seen     = 3'd1;
            state_o.lead     = byte_i;
          end else begin
            res_valid_o        = 1'b1;
            res_o.seq_bytes    = 3'd1;
            res_o.decode_error = 1'b1;
            state_o            = '0;
          end
        end else begin
          // overlong forms caught on the second byte
          if (state_i.seen == 3'd1) begin
            if (state_i.lead == 8'hE0 && byte_i < 8'hA0) cont_ok = 1'b0;
            if (state_i.lead == 8'hF0 && byte_i < 8'h90) cont_ok = 1'b0;
            if (state_i.lead == 8'hF8 && byte_i < 8'h88) cont_ok = 1'b0;
            if (state_i.lead == 8'hFC && byte_i < 8'h84) cont_ok = 1'b0;
          end
          if (!cont_ok) begin
            res_valid_o        = 1'b1;
            res_o.seq_bytes    = seen_inc;
            res_o.decode_error = 1'b1;
            state_o            = '0;
          end else if (seen_inc >= state_i.expected) begin
            res_valid_o      = 1'b1;
            res_o.code_point = acc8[30:0];
            res_o.seq_bytes  = state_i.expected;
            state_o          = '0;
          end else begin
            state_o.acc  = acc8;
            state_o.seen = seen_inc;
          end
        end
      end

      ubsd_pkg::FMT_UTF16LE, ubsd_pkg::FMT_UTF16BE: begin
        if (state_i.seen == 3'd0) begin
          state_o.acc  = {24'd0, byte_i};
          state_o.seen = 3'd1;
        end else begin
          state_o.acc  = '0;
          state_o.seen = 3'd0;
          if (state_i.pair_pending) begin
            res_valid_o     = 1'b1;
            res_o.seq_bytes = 3'd4;
            state_o         = '0;
            if (unit >= ubsd_pkg::SurLowLo && unit < ubsd_pkg::SurEnd) begin
              res_o.code_point = ubsd_pkg::SupplBase[30:0]
                                 + {11'd0, state_i.high_sur[9:0], unit[9:0]};
            end else begin
              res_o.decode_error = 1'b1;
            end
          end else if (unit >= ubsd_pkg::SurLowLo && unit < ubsd_pkg::SurEnd) begin
            res_valid_o        = 1'b1;
            res_o.seq_bytes    = 3'd2;
            res_o.decode_error = 1'b1;
            state_o            = '0;
          end else if (unit >= ubsd_pkg::SurHighLo) begin
            state_o.high_sur     = unit;
            state_o.pair_pending = 1'b1;
          end else begin
            res_valid_o      = 1'b1;
            res_o.code_point = {15'd0, unit};
            res_o.seq_bytes  = 3'd2;
            state_o          = '0;
          end
          // with no pair pending, units at or above the surrogate range end are plain characters
          if (!state_i.pair_pending && unit >= ubsd_pkg::SurEnd) begin
            res_valid_o          = 1'b1;
            res_o.code_point     = {15'd0, unit};
            res_o.seq_bytes      = 3'd2;
            res_o.decode_error   = 1'b0;
            state_o              = '0;
          end
        end
      end

      ubsd_pkg::FMT_UTF32LE, ubsd_pkg::FMT_UTF32BE: begin
        if (pos == 2'd3) begin
          res_valid_o     = 1'b1;
          res_o.seq_bytes = 3'd4;
          state_o         = '0;
          if (acc32 < ubsd_pkg::MaxCpEnd &&
              !(acc32 >= {16'd0, ubsd_pkg::SurHighLo} && acc32 < {16'd0, ubsd_pkg::SurEnd}))
          begin
            res_o.code_point = acc32[30:0];
          end else begin
            res_o.decode_error = 1'b1;
          end
        end else begin
          state_o.acc  = acc32;
          state_o.seen = {1'b0, pos} + 3'd1;
        end
      end

      default: begin
        // unused format codes leave everything untouched
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/ubsd_out_reg.sv]
// result register on the master side of the decoder
`default_nettype none

module ubsd_out_reg (
  input  var logic                                clk_i,
  input  var logic                                rst_ni,
  input  var logic                                push_i,
  input  var ubsd_pkg::dec_result_t               res_i,
  output logic                                    space_o,
  output logic                                    m_axis_tvalid,
  input  var logic                                m_axis_tready,
  output logic [ubsd_pkg::OutDataW-1:0]           m_axis_tdata,
  output logic                                    m_axis_tuser
);

  logic                  valid_q, valid_d;
  ubsd_pkg::dec_result_t res_q;

  // room when empty or when the held transaction leaves this cycle
  assign space_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(ubsd_pkg::OutDataW - ubsd_pkg::OutUsedW){1'b0}},
                          res_q.seq_bytes, res_q.code_point};
  assign m_axis_tuser  = res_q.decode_error;

endmodule

`default_nettype wire

[hw/rtl/unicode_byte_stream_decoder.sv]
// Unicode byte stream decoder: one encoded byte in, decoded code points out.
//
// Slave stream takes one raw byte per transaction in s_axis_tdata. The master
// stream gives one transaction per finished character or failed sequence:
// code point and consumed byte count in m_axis_tdata, the error flag in
// m_axis_tuser. Bytes that do not finish a character give no transaction.
// cfg_we_i writes the input format (0 utf8, 1/2 utf16 le/be, 3/4 utf32 le/be)
// and clears any partial sequence; write it only while the stream is idle.
// A byte is decoded in the cycle it is taken and its result sits in the output
// register in the next cycle; throughput is one byte per clock while the single
// result register has room, as set by that register and its handshake.
// Reset selects utf8, clears the sequence state and empties the output.
// When the receiver stalls the result is held and s_axis_tready drops only
// while that register is full and not being drained.
`default_nettype none

module unicode_byte_stream_decoder (
  input  var logic                            clk_i,
  input  var logic                            rst_ni,
  input  var logic                            cfg_we_i,
  input  var logic [2:0]                      cfg_wdata_i,    // input_format
  input  var logic                            s_axis_tvalid,
  output logic                                s_axis_tready,
  input  var logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
  output logic                                m_axis_tvalid,
  input  var logic                            m_axis_tready,
  // [30:0] code_point, [33:31] seq_bytes, [39:34] zero
  output logic [ubsd_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                m_axis_tuser    // [0] decode_error
);

  logic [2:0]            format_q, format_d;
  ubsd_pkg::dec_state_t  state_q, state_d, state_nxt;
  logic                  res_valid;
  ubsd_pkg::dec_result_t res;
  logic                  space;
  logic                  accept;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  ubsd_step u_step (
    .state_i     (state_q),
    .format_i    (format_q),
    .byte_i      (s_axis_tdata),
    .state_o     (state_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ubsd_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (accept && res_valid),
    .res_i         (res),
    .space_o       (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always_comb begin
    format_d = format_q;
    state_d  = state_q;
    priority if (cfg_we_i) begin
      format_d = cfg_wdata_i;
      state_d  = '0;
    end else if (accept) begin
      state_d = state_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= ubsd_pkg::FMT_UTF8;
      state_q  <= '0;
    end else begin
      format_q <= format_d;
      state_q  <= state_d;
    end
  end

endmodule

`default_nettype wire
